>>> design/gwg_pkg.sv
// ----------------------------------------------------------------------------
// gwg_pkg
// Shared types, constants and fixed-point helpers for the grain window
// generator.
// ----------------------------------------------------------------------------
package gwg_pkg;

    typedef enum logic [2:0] {
        WIN_GAUSS    = 3'd0,
        WIN_COSINE   = 3'd1,
        WIN_TRIANGLE = 3'd2,
        WIN_RECT     = 3'd3,
        WIN_HANN     = 3'd4
    } win_type_t;

    typedef enum logic {
        RCP_IDLE,
        RCP_RUN
    } rcp_state_t;

    localparam logic REG_WINDOW_TYPE   = 1'b0;
    localparam logic REG_WINDOW_LENGTH = 1'b1;

    localparam int LEN_W          = 13;
    localparam int POS_W          = 12;
    localparam int RCP_W          = 45;
    localparam int Q_W            = 31;
    localparam int GAIN_FRAC_BITS = 15;

    localparam logic [LEN_W-1:0] MAX_LENGTH   = 13'd4096;
    localparam logic [LEN_W-1:0] LENGTH_RESET = 13'd1024;
    localparam logic [5:0]       RCP_LAST     = 6'(RCP_W - 1);

    localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
    localparam logic [31:0] HALF_Q30 = 32'h2000_0000;
    localparam logic [31:0] PI_Q30   = 32'd3373259426;

    localparam logic [6:0] C_72 = 7'd72;
    localparam logic [6:0] C_42 = 7'd42;
    localparam logic [6:0] C_20 = 7'd20;
    localparam logic [6:0] C_6  = 7'd6;
    localparam logic [6:0] C_5  = 7'd5;
    localparam logic [6:0] C_4  = 7'd4;
    localparam logic [6:0] C_3  = 7'd3;
    localparam logic [6:0] C_2  = 7'd2;

    localparam logic [31:0] MAG_72 = 32'(64'h1_0000_0000 / 72);
    localparam logic [31:0] MAG_42 = 32'(64'h1_0000_0000 / 42);
    localparam logic [31:0] MAG_20 = 32'(64'h1_0000_0000 / 20);
    localparam logic [31:0] MAG_6  = 32'(64'h1_0000_0000 / 6);
    localparam logic [31:0] MAG_5  = 32'(64'h1_0000_0000 / 5);
    localparam logic [31:0] MAG_4  = 32'(64'h1_0000_0000 / 4);
    localparam logic [31:0] MAG_3  = 32'(64'h1_0000_0000 / 3);
    localparam logic [31:0] MAG_2  = 32'(64'h1_0000_0000 / 2);

    function automatic logic [31:0] mulq(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b};
        return p[61:30];
    endfunction

    function automatic logic [31:0] cdiv_est(input logic [31:0] t, input logic [31:0] m);
        logic [63:0] p;
        p = {32'd0, t} * {32'd0, m};
        return p[63:32];
    endfunction

    function automatic logic [31:0] cdiv_fix(input logic [31:0] t, input logic [31:0] qm,
                                             input logic [6:0] c);
        logic [31:0] r;
        r = t - qm * {25'd0, c};
        return (r >= {25'd0, c}) ? qm + 32'd1 : qm;
    endfunction

    function automatic logic [15:0] to_gain(input logic [31:0] v);
        logic [31:0] s;
        logic [31:0] r;
        s = (v > ONE_Q30) ? ONE_Q30 : v;
        r = s + (32'd1 << (29 - GAIN_FRAC_BITS));
        return r[30-GAIN_FRAC_BITS +: 16];
    endfunction

endpackage

>>> design/grain_window_generator_top.sv
// ----------------------------------------------------------------------------
// grain_window_generator_top
// Window gain for a sample position: Gaussian, cosine, triangle, rectangle,
// Hann, returned as unsigned Q1.15.
// ----------------------------------------------------------------------------
// Accepts one position per cycle while in_stall is low and returns its gain
// from the registered pipeline output; a stall on the output freezes the
// whole pipeline. The divisions by the window length, or by the length minus
// one, use reciprocals held in registers, produced by a bit-serial divider
// that runs after reset and after every write of window_length; the input is
// stalled during that time. Configuration writes are always taken.
module grain_window_generator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [11:0] position,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] gain,
    output logic        out_of_range,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int NS = 22;

    logic [2:0]  window_type_reg;
    logic [12:0] window_length_reg;

    gwg_pkg::rcp_state_t rcp_state_reg, rcp_state_next;
    logic [5:0]  rcp_cnt_reg, rcp_cnt_next;
    logic [12:0] rem_l_reg, rem_l_next, rem_m_reg, rem_m_next;
    logic [44:0] rcp_l_reg, rcp_l_next, rcp_m_reg, rcp_m_next;

    logic        en;
    logic        rcp_busy;
    logic        cfg_fire;
    logic [12:0] lenc, lm1, dl, dm;

    logic        vld_reg [1:NS];
    logic [2:0]  typ_reg [1:NS-1];
    logic        oor_reg [1:NS-1];

    logic [12:0] n1_reg, d1_reg, n2_reg, d2_reg, n3_reg, d3_reg, n4_reg, d4_reg;
    logic [44:0] r1_reg;
    logic        z1_reg, z2_reg, z3_reg, z4_reg;
    logic [57:0] prod2_reg;
    logic [30:0] qe3_reg, qe4_reg;
    logic [43:0] qd4_reg;
    logic [30:0] q_reg [5:NS-1];

    logic [31:0] sa_reg [6:18];
    logic [31:0] sw_reg [6:20];
    logic [31:0] st_reg [8:17];
    logic [31:0] ar_reg [8:15];
    logic [31:0] sn_reg [20:21];
    logic [31:0] hn_reg;

    logic [31:0] gw_reg [6:NS-1];
    logic [31:0] gt_reg [7:16];
    logic [31:0] gz_reg [7:17];

    logic [15:0] gain_reg;
    logic        oor_out_reg;

    logic [12:0] s1_n, s1_d;
    logic [44:0] s1_r;
    logic        s1_z, s1_oor;
    logic [31:0] xf;
    logic [42:0] rem5;
    logic [30:0] q5;
    logic [31:0] v_sel;
    logic [31:0] hs;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign rcp_busy  = (rcp_state_reg == gwg_pkg::RCP_RUN);
    assign en        = ~vld_reg[NS] | ~out_stall;
    assign in_stall  = ~en | rcp_busy;

    assign lenc = (window_length_reg > gwg_pkg::MAX_LENGTH) ? gwg_pkg::MAX_LENGTH
                                                           : window_length_reg;
    assign lm1  = lenc - 13'd1;
    assign dl   = (lenc == 13'd0) ? 13'd1 : lenc;
    assign dm   = (lm1 == 13'd0 || lenc == 13'd0) ? 13'd1 : lm1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_type_reg   <= 3'd0;
            window_length_reg <= gwg_pkg::LENGTH_RESET;
        end
        else if (cfg_fire)
        begin
            if (cfg_index == gwg_pkg::REG_WINDOW_TYPE)
            begin
                window_type_reg <= cfg_data[2:0];
            end
            else
            begin
                window_length_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcp_state_reg <= gwg_pkg::RCP_RUN;
            rcp_cnt_reg   <= gwg_pkg::RCP_LAST;
            rem_l_reg     <= 13'd0;
            rem_m_reg     <= 13'd0;
        end
        else
        begin
            rcp_state_reg <= rcp_state_next;
            rcp_cnt_reg   <= rcp_cnt_next;
            rem_l_reg     <= rem_l_next;
            rem_m_reg     <= rem_m_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rcp_l_reg <= rcp_l_next;
        rcp_m_reg <= rcp_m_next;
    end

    always_comb
    begin
        logic        lead;
        logic [13:0] shl, shm;
        rcp_state_next = rcp_state_reg;
        rcp_cnt_next   = rcp_cnt_reg;
        rem_l_next     = rem_l_reg;
        rem_m_next     = rem_m_reg;
        rcp_l_next     = rcp_l_reg;
        rcp_m_next     = rcp_m_reg;
        lead = (rcp_cnt_reg == gwg_pkg::RCP_LAST);
        shl  = {rem_l_reg, lead};
        shm  = {rem_m_reg, lead};
        case (rcp_state_reg)
            gwg_pkg::RCP_RUN:
            begin
                if (shl >= {1'b0, dl})
                begin
                    rem_l_next = 13'(shl - {1'b0, dl});
                    rcp_l_next = {rcp_l_reg[43:0], 1'b1};
                end
                else
                begin
                    rem_l_next = shl[12:0];
                    rcp_l_next = {rcp_l_reg[43:0], 1'b0};
                end
                if (shm >= {1'b0, dm})
                begin
                    rem_m_next = 13'(shm - {1'b0, dm});
                    rcp_m_next = {rcp_m_reg[43:0], 1'b1};
                end
                else
                begin
                    rem_m_next = shm[12:0];
                    rcp_m_next = {rcp_m_reg[43:0], 1'b0};
                end
                rcp_cnt_next = rcp_cnt_reg - 6'd1;
                if (rcp_cnt_reg == 6'd0)
                begin
                    rcp_state_next = gwg_pkg::RCP_IDLE;
                end
            end
            default:
            begin
                rcp_state_next = gwg_pkg::RCP_IDLE;
            end
        endcase
        if (cfg_fire && cfg_index == gwg_pkg::REG_WINDOW_LENGTH)
        begin
            rcp_state_next = gwg_pkg::RCP_RUN;
            rcp_cnt_next   = gwg_pkg::RCP_LAST;
            rem_l_next     = 13'd0;
            rem_m_next     = 13'd0;
        end
    end

    always_comb
    begin
        logic [12:0] p13, m, mir;
        logic [13:0] p2, len14;
        p13   = {1'b0, position};
        mir   = lm1 - p13;
        m     = (p13 < mir) ? p13 : mir;
        p2    = {1'b0, p13} << 1;
        len14 = {1'b0, lenc};
        s1_oor = (p13 >= lenc);
        s1_z   = (window_type_reg != gwg_pkg::WIN_GAUSS) && (lm1 == 13'd0);
        case (window_type_reg)
            gwg_pkg::WIN_GAUSS:
            begin
                s1_n = (p2 >= len14) ? 13'(p2 - len14) : 13'(len14 - p2);
                s1_r = rcp_l_reg;
                s1_d = dl;
            end
            gwg_pkg::WIN_TRIANGLE:
            begin
                s1_n = {m[11:0], 1'b0};
                s1_r = rcp_m_reg;
                s1_d = dm;
            end
            default:
            begin
                s1_n = p13;
                s1_r = rcp_m_reg;
                s1_d = dm;
            end
        endcase
    end

    assign rem5 = {n4_reg, 30'd0} - qd4_reg[42:0];
    assign q5   = z4_reg ? 31'd0
                : ((rem5 >= {30'd0, d4_reg}) ? qe4_reg + 31'd1 : qe4_reg);
    assign xf   = ({1'b0, q_reg[5]} > gwg_pkg::HALF_Q30)
                ? ((({1'b0, q_reg[5]} > gwg_pkg::ONE_Q30) ? 32'd0
                    : gwg_pkg::ONE_Q30 - {1'b0, q_reg[5]}))
                : {1'b0, q_reg[5]};
    assign hs   = (sw_reg[19] > gwg_pkg::ONE_Q30) ? gwg_pkg::ONE_Q30 : sw_reg[19];

    always_comb
    begin
        case (typ_reg[NS-1])
            gwg_pkg::WIN_GAUSS:    v_sel = gw_reg[NS-1];
            gwg_pkg::WIN_COSINE:   v_sel = sn_reg[21];
            gwg_pkg::WIN_TRIANGLE: v_sel = {1'b0, q_reg[NS-1]};
            gwg_pkg::WIN_RECT:     v_sel = gwg_pkg::ONE_Q30;
            gwg_pkg::WIN_HANN:     v_sel = hn_reg;
            default:               v_sel = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= NS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[1] <= in_valid & ~rcp_busy;
            for (int k = 2; k <= NS; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            typ_reg[1] <= window_type_reg;
            oor_reg[1] <= s1_oor;
            for (int k = 2; k <= NS-1; k++)
            begin
                typ_reg[k] <= typ_reg[k-1];
                oor_reg[k] <= oor_reg[k-1];
            end

            n1_reg <= s1_n;
            d1_reg <= s1_d;
            r1_reg <= s1_r;
            z1_reg <= s1_z;

            prod2_reg <= 58'(n1_reg) * 58'(r1_reg);
            n2_reg    <= n1_reg;
            d2_reg    <= d1_reg;
            z2_reg    <= z1_reg;

            qe3_reg <= prod2_reg[44:14];
            n3_reg  <= n2_reg;
            d3_reg  <= d2_reg;
            z3_reg  <= z2_reg;

            qd4_reg <= 44'(qe3_reg) * 44'(d3_reg);
            qe4_reg <= qe3_reg;
            n4_reg  <= n3_reg;
            d4_reg  <= d3_reg;
            z4_reg  <= z3_reg;

            q_reg[5] <= q5;
            for (int k = 6; k <= NS-1; k++)
            begin
                q_reg[k] <= q_reg[k-1];
            end

            sa_reg[6] <= gwg_pkg::mulq(gwg_pkg::PI_Q30, xf);
            for (int k = 7; k <= 18; k++)
            begin
                sa_reg[k] <= sa_reg[k-1];
            end
            sw_reg[6]  <= 32'd0;
            sw_reg[7]  <= gwg_pkg::mulq(sa_reg[6], sa_reg[6]);
            sw_reg[8]  <= gwg_pkg::cdiv_est(sw_reg[7], gwg_pkg::MAG_72);
            st_reg[8]  <= sw_reg[7];
            ar_reg[8]  <= sw_reg[7];
            for (int k = 9; k <= 15; k++)
            begin
                ar_reg[k] <= ar_reg[k-1];
            end
            sw_reg[9]  <= gwg_pkg::ONE_Q30
                        - gwg_pkg::cdiv_fix(st_reg[8], sw_reg[8], gwg_pkg::C_72);
            st_reg[9]  <= st_reg[8];
            sw_reg[10] <= gwg_pkg::mulq(ar_reg[9], sw_reg[9]);
            st_reg[10] <= st_reg[9];
            sw_reg[11] <= gwg_pkg::cdiv_est(sw_reg[10], gwg_pkg::MAG_42);
            st_reg[11] <= sw_reg[10];
            sw_reg[12] <= gwg_pkg::ONE_Q30
                        - gwg_pkg::cdiv_fix(st_reg[11], sw_reg[11], gwg_pkg::C_42);
            st_reg[12] <= st_reg[11];
            sw_reg[13] <= gwg_pkg::mulq(ar_reg[12], sw_reg[12]);
            st_reg[13] <= st_reg[12];
            sw_reg[14] <= gwg_pkg::cdiv_est(sw_reg[13], gwg_pkg::MAG_20);
            st_reg[14] <= sw_reg[13];
            sw_reg[15] <= gwg_pkg::ONE_Q30
                        - gwg_pkg::cdiv_fix(st_reg[14], sw_reg[14], gwg_pkg::C_20);
            st_reg[15] <= st_reg[14];
            sw_reg[16] <= gwg_pkg::mulq(ar_reg[15], sw_reg[15]);
            st_reg[16] <= st_reg[15];
            sw_reg[17] <= gwg_pkg::cdiv_est(sw_reg[16], gwg_pkg::MAG_6);
            st_reg[17] <= sw_reg[16];
            sw_reg[18] <= gwg_pkg::ONE_Q30
                        - gwg_pkg::cdiv_fix(st_reg[17], sw_reg[17], gwg_pkg::C_6);
            sw_reg[19] <= gwg_pkg::mulq(sa_reg[18], sw_reg[18]);
            sw_reg[20] <= gwg_pkg::mulq(hs, hs);
            sn_reg[20] <= sw_reg[19];
            sn_reg[21] <= sn_reg[20];
            hn_reg     <= sw_reg[20] | sw_reg[6];

            gw_reg[6]  <= gwg_pkg::mulq({1'b0, q_reg[5]}, {1'b0, q_reg[5]}) >> 2;
            gz_reg[7]  <= gw_reg[6];
            for (int k = 8; k <= 17; k++)
            begin
                gz_reg[k] <= gz_reg[k-1];
            end
            gw_reg[7]  <= gwg_pkg::cdiv_est(gw_reg[6], gwg_pkg::MAG_5);
            gt_reg[7]  <= gw_reg[6];
            gw_reg[8]  <= gwg_pkg::ONE_Q30
                        - gwg_pkg::cdiv_fix(gt_reg[7], gw_reg[7], gwg_pkg::C_5);
            gt_reg[8]  <= gt_reg[7];
            gw_reg[9]  <= gwg_pkg::mulq(gz_reg[8], gw_reg[8]);
            gt_reg[9]  <= gt_reg[8];
            gw_reg[10] <= gwg_pkg::cdiv_est(gw_reg[9], gwg_pkg::MAG_4);
            gt_reg[10] <= gw_reg[9];
            gw_reg[11] <= gwg_pkg::ONE_Q30
                        - gwg_pkg::cdiv_fix(gt_reg[10], gw_reg[10], gwg_pkg::C_4);
            gt_reg[11] <= gt_reg[10];
            gw_reg[12] <= gwg_pkg::mulq(gz_reg[11], gw_reg[11]);
            gt_reg[12] <= gt_reg[11];
            gw_reg[13] <= gwg_pkg::cdiv_est(gw_reg[12], gwg_pkg::MAG_3);
            gt_reg[13] <= gw_reg[12];
            gw_reg[14] <= gwg_pkg::ONE_Q30
                        - gwg_pkg::cdiv_fix(gt_reg[13], gw_reg[13], gwg_pkg::C_3);
            gt_reg[14] <= gt_reg[13];
            gw_reg[15] <= gwg_pkg::mulq(gz_reg[14], gw_reg[14]);
            gt_reg[15] <= gt_reg[14];
            gw_reg[16] <= gwg_pkg::cdiv_est(gw_reg[15], gwg_pkg::MAG_2);
            gt_reg[16] <= gw_reg[15];
            gw_reg[17] <= gwg_pkg::ONE_Q30
                        - gwg_pkg::cdiv_fix(gt_reg[16], gw_reg[16], gwg_pkg::C_2);
            gw_reg[18] <= gwg_pkg::ONE_Q30 - gwg_pkg::mulq(gz_reg[17], gw_reg[17]);
            gw_reg[19] <= gwg_pkg::mulq(gw_reg[18], gw_reg[18]);
            gw_reg[20] <= gwg_pkg::mulq(gw_reg[19], gw_reg[19]);
            gw_reg[21] <= gwg_pkg::mulq(gw_reg[20], gw_reg[20]);

            gain_reg    <= oor_reg[NS-1] ? 16'd0 : gwg_pkg::to_gain(v_sel);
            oor_out_reg <= oor_reg[NS-1];
        end
    end

    assign out_valid    = vld_reg[NS];
    assign gain         = gain_reg;
    assign out_of_range = oor_out_reg;

endmodule

>>> design/gwg_checker.sv
// ----------------------------------------------------------------------------
// gwg_checker
// Port-level checks for the grain window generator, bound to the top level.
// ----------------------------------------------------------------------------
module gwg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] gain,
    input logic        out_of_range
);

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> gain == 16'd0)
        else $error("out_of_range result with nonzero gain");

    a_gain_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> gain <= 16'd32768)
        else $error("gain above unity");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(gain) && $stable(out_of_range))
        else $error("stalled output transfer changed");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while output is stalled");

endmodule

bind grain_window_generator_top gwg_checker u_gwg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .gain         (gain),
    .out_of_range (out_of_range)
);
